// ----- src/scmq_pkg.sv -----
`default_nettype none

package scmq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [7:0] BYTE_DRV_RESET = 8'h01;
  localparam logic [7:0] BYTE_SPECIAL   = 8'h02;
  localparam logic [7:0] BYTE_STOP_ALL  = 8'h03;

  typedef enum logic [1:0] {
    CMD_PLAY  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PREFIX_EN   = 2'd0,
    CFG_PREFIX_CODE = 2'd1,
    CFG_STOP_EN     = 2'd2,
    CFG_STOP_BYTE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic              load;
    logic              push;
    logic              tick;
    logic [SLOT_W-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/scmq_if.sv -----
`default_nettype none

interface scmq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] sound_code;

  modport source (output valid, output cmd, output sound_code, input ready);
  modport sink   (input valid, input cmd, input sound_code, output ready);
endinterface

interface scmq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sent_code;
  logic [5:0] pending_after;

  modport source (output valid, output sent_code, output pending_after, input ready);
  modport sink   (input valid, input sent_code, input pending_after, output ready);
endinterface

interface scmq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/scmq_ram.sv -----
`default_nettype none

module scmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/scmq_ctrl.sv -----
`default_nettype none

module scmq_ctrl
  import scmq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       ctrl_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    ctrl_o     = '0;
    ctrl_o.slot = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        accept     = in_valid_i && status_i.out_free;
        if (accept) begin
          if (cmd_e'(in_cmd_i) == CMD_TICK) begin
            state_d = ST_SEND;
          end else begin
            ctrl_o.load = 1'b1;
            slot_d      = '0;
            state_d     = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        ctrl_o.push = 1'b1;
        if (slot_q == SLOT_W'(NUM_SLOTS - 1)) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      ST_SEND: begin
        ctrl_o.tick = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/scmq_dp.sv -----
`default_nettype none

module scmq_dp
  import scmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctrl_cmd_t  ctrl_i,
  output dp_status_t      status_o,
  input  wire logic [1:0] in_cmd_i,
  input  wire logic [7:0] in_code_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_code_o,
  output logic [5:0]      out_pending_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic       prefix_en_q;
  logic [7:0] prefix_code_q;
  logic       stop_en_q;
  logic [7:0] stop_byte_q;

  logic [7:0]           slot_q [NUM_SLOTS];
  logic [7:0]           slot_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_en_q, slot_en_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic          send_wait_q, send_wait_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_code_q, out_code_d;
  logic [5:0] out_pend_q, out_pend_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    rdata;
  logic [CW:0]   wr_sum;
  logic [CW:0]   wr_wrap;
  logic [CW-1:0] cnt_dec;
  logic [CW+5:0] pend_ext;
  logic [AW-1:0] head_inc;
  logic          is_play, is_special, stop_is_03;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_en_q   <= 1'b0;
      prefix_code_q <= '0;
      stop_en_q     <= 1'b0;
      stop_byte_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PREFIX_EN:   prefix_en_q   <= cfg_data_i[0];
        CFG_PREFIX_CODE: prefix_code_q <= cfg_data_i;
        CFG_STOP_EN:     stop_en_q     <= cfg_data_i[0];
        CFG_STOP_BYTE:   stop_byte_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot order: prefix/stop-all, stop, 03, prefix/02, code; driver reset loads 01, 03.
  always_comb begin
    is_play    = cmd_e'(in_cmd_i) == CMD_PLAY;
    is_special = in_code_i == BYTE_SPECIAL;
    stop_is_03 = stop_byte_q == BYTE_STOP_ALL;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_d[i] = slot_q[i];
    end
    slot_en_d = slot_en_q;
    if (ctrl_i.load) begin
      if (cmd_e'(in_cmd_i) == CMD_RESET) begin
        slot_d[0] = BYTE_DRV_RESET;
        slot_d[1] = BYTE_STOP_ALL;
        slot_d[2] = BYTE_STOP_ALL;
        slot_d[3] = BYTE_STOP_ALL;
        slot_d[4] = BYTE_STOP_ALL;
        slot_en_d = NUM_SLOTS'(2'b11);
      end else begin
        slot_d[0]    = stop_is_03 ? BYTE_STOP_ALL : prefix_code_q;
        slot_d[1]    = stop_byte_q;
        slot_d[2]    = BYTE_STOP_ALL;
        slot_d[3]    = is_special ? BYTE_SPECIAL : prefix_code_q;
        slot_d[4]    = in_code_i;
        slot_en_d[0] = stop_is_03 || prefix_en_q;
        slot_en_d[1] = !stop_is_03 && stop_en_q;
        slot_en_d[2] = is_play && (is_special || prefix_en_q);
        slot_en_d[3] = is_play && (is_special || prefix_en_q);
        slot_en_d[4] = is_play && !is_special;
      end
    end
  end

  always_comb begin
    wr_sum   = (CW+1)'(count_q) + (CW+1)'(head_q);
    wr_wrap  = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ? wr_sum - (CW+1)'(QUEUE_DEPTH) : wr_sum;
    waddr    = wr_wrap[AW-1:0];
    cnt_dec  = count_q - 1'b1;
    pend_ext = (CW+6)'(cnt_dec);
    head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

    count_d     = count_q;
    head_d      = head_q;
    send_wait_d = send_wait_q;
    we          = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_code_d  = out_code_q;
    out_pend_d  = out_pend_q;

    if (ctrl_i.load && cmd_e'(in_cmd_i) == CMD_RESET) begin
      count_d = '0;
      head_d  = '0;
    end
    if (ctrl_i.push && slot_en_q[ctrl_i.slot] && count_q != CW'(QUEUE_DEPTH)) begin
      we      = 1'b1;
      count_d = count_q + 1'b1;
    end
    if (ctrl_i.tick) begin
      if (!send_wait_q && count_q != '0) begin
        out_valid_d = 1'b1;
        out_code_d  = rdata;
        out_pend_d  = pend_ext[5:0];
        count_d     = cnt_dec;
        head_d      = head_inc;
        send_wait_d = 1'b1;
      end else begin
        send_wait_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_en_q   <= '0;
      count_q     <= '0;
      head_q      <= '0;
      send_wait_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_en_q   <= slot_en_d;
      count_q     <= count_d;
      head_q      <= head_d;
      send_wait_q <= send_wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_q[i] <= slot_d[i];
    end
    out_code_q <= out_code_d;
    out_pend_q <= out_pend_d;
  end

  scmq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (slot_q[ctrl_i.slot]),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_code_o        = out_code_q;
  assign out_pending_o     = out_pend_q;

endmodule

`default_nettype wire

// ----- src/sound_command_mailbox_queue.sv -----
// Channel | Dir | Payload                          | Request
// in_ch   | in  | cmd[1:0], sound_code[7:0]        | play, stop, tick or driver reset
// out_ch  | out | sent_code[7:0], pending_after[5:0] | one mailbox byte per sending tick
// cfg_ch  | in  | index[1:0], data[7:0]            | register write, always ready
//
// Play, stop and driver reset are accepted, then walk five slots that each do
// at most one queue RAM write. A tick is accepted; unless the queue is empty or
// the last tick sent, the registered head RAM read lands in the output register.
// A new request is taken once the controller is idle and the output register is
// free or being drained. Reset clears control state; the queue RAM is not cleared.
`default_nettype none

module sound_command_mailbox_queue
  import scmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  scmq_in_if.sink     in_ch,
  scmq_out_if.source  out_ch,
  scmq_cfg_if.sink    cfg_ch
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  scmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_cmd_i   (in_ch.cmd),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  scmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_cmd_i      (in_ch.cmd),
    .in_code_i     (in_ch.sound_code),
    .cfg_we_i      (cfg_ch.valid),
    .cfg_index_i   (cfg_ch.index),
    .cfg_data_i    (cfg_ch.data),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_code_o    (out_ch.sent_code),
    .out_pending_o (out_ch.pending_after)
  );

endmodule

`default_nettype wire

// ----- src/scmq_checker.sv -----
`default_nettype none

module scmq_checker
  import scmq_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_code
);

  logic in_acc;
  logic in_tick;

  assign in_acc  = in_valid && in_ready;
  assign in_tick = in_acc && (cmd_e'(in_cmd) == CMD_TICK);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("stalled result changed");

  a_rose_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_tick, 2))
    else $error("result without a preceding tick");

  a_no_result_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_tick |=> !$rose(out_valid))
    else $error("queue request produced a result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind sound_command_mailbox_queue scmq_checker u_scmq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_code  (out_ch.sent_code)
);

`default_nettype wire
